>>> rtl/cluster_purity_error_counter_defines.svh
// Assertion macros for the cluster purity error counter.
`ifndef CLUSTER_PURITY_ERROR_COUNTER_DEFINES_SVH
`define CLUSTER_PURITY_ERROR_COUNTER_DEFINES_SVH
`ifndef SYNTHESIS
`define CPEC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpec: same-cycle check failed");
`define CPEC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpec: next-cycle check failed");
`else
`define CPEC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CPEC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/cpec_pkg.sv
// Shared types and constants for the cluster purity error counter.
`timescale 1ns / 1ps
`default_nettype none
package cpec_pkg;

  localparam int MaxXDef       = 16;
  localparam int MaxYDef       = 16;
  localparam int NumClassesDef = 20;
  localparam int CountWidthDef = 16;

  localparam int TotW     = 32;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 5;

  localparam logic [CfgIdxW-1:0] CfgMapWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMapHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgEnable    = 2'd2;

  localparam logic [CfgDataW-1:0] MapWidthRst  = 5'd16;
  localparam logic [CfgDataW-1:0] MapHeightRst = 5'd16;

  typedef enum logic [1:0] {
    ST_REPORT      = 2'd0,
    ST_CLASS_RANGE = 2'd1,
    ST_CELL_RANGE  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INC,
    S_SWEEP,
    S_DRAIN
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic rd_sample;
    logic wr_sample;
    logic sweep_rd;
    logic sweep_acc;
    logic acc_clear;
    logic load_err;
    logic load_report;
  } cmd_t;

  typedef struct packed {
    logic item_finish;
    logic item_count;
    logic item_error;
    logic sweep_last;
    logic pipe_empty;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/cpec_ctrl.sv
// Controller state machine: sample update, sweep sequencing, result loads.
`timescale 1ns / 1ps
`default_nettype none
module cpec_ctrl
  import cpec_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   report_q, report_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_SWEEP;   // power-on clearing sweep
      report_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      report_q <= report_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    report_d = report_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && sts_i.out_free) begin
          if (sts_i.item_finish) begin
            state_d  = S_SWEEP;
            report_d = 1'b1;
          end else if (sts_i.item_count) begin
            state_d = S_INC;
          end
        end
      end
      S_INC: state_d = S_IDLE;
      S_SWEEP: begin
        if (sts_i.sweep_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts_i.pipe_empty) begin
          state_d  = S_IDLE;
          report_d = 1'b0;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          if (sts_i.item_finish) begin
            cmd_o.acc_clear = 1'b1;
          end else if (sts_i.item_count) begin
            cmd_o.rd_sample = 1'b1;
          end else if (sts_i.item_error) begin
            cmd_o.load_err = 1'b1;
          end
        end
      end
      S_INC: cmd_o.wr_sample = 1'b1;
      S_SWEEP: begin
        cmd_o.sweep_rd  = 1'b1;
        cmd_o.sweep_acc = report_q;
      end
      S_DRAIN: cmd_o.load_report = sts_i.pipe_empty && report_q;
      default: cmd_o = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/cpec_datapath.sv
// Datapath: config registers, histogram memory, sweep accumulators, result register.
`timescale 1ns / 1ps
`default_nettype none
module cpec_datapath
  import cpec_pkg::*;
#(
  parameter int MAX_X       = MaxXDef,
  parameter int MAX_Y       = MaxYDef,
  parameter int NUM_CLASSES = NumClassesDef,
  parameter int COUNT_WIDTH = CountWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                kind_i,
  input  logic signed [5:0]   class_label_i,
  input  logic [3:0]          cell_x_i,
  input  logic [3:0]          cell_y_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [1:0]          status_o,
  output logic [TotW-1:0]     total_items_o,
  output logic [TotW-1:0]     wrong_items_o
);

  localparam int XW     = (MAX_X > 1) ? $clog2(MAX_X) : 1;
  localparam int YW     = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
  localparam int KW     = $clog2(NUM_CLASSES);
  localparam int AW     = XW + YW + KW;
  localparam int DEPTH  = 1 << AW;
  localparam int PART_W = COUNT_WIDTH + KW;
  localparam int SUM_W  = ((PART_W > TotW) ? PART_W : TotW) + 1;

  // configuration
  logic [CfgDataW-1:0] map_w_q, map_h_q;
  logic                en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_w_q <= MapWidthRst;
      map_h_q <= MapHeightRst;
      en_q    <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgMapWidth:  map_w_q <= cfg_data_i;
        CfgMapHeight: map_h_q <= cfg_data_i;
        CfgEnable:    en_q    <= cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  // item decode
  logic    neg, class_big, cell_bad;
  logic [AW-1:0] sample_addr;

  assign neg       = class_label_i[5];
  assign class_big = !neg && (32'(class_label_i[4:0]) >= NUM_CLASSES);
  assign cell_bad  = (32'(cell_x_i) >= 32'(map_w_q)) || (32'(cell_x_i) >= MAX_X) ||
                     (32'(cell_y_i) >= 32'(map_h_q)) || (32'(cell_y_i) >= MAX_Y);
  assign sample_addr = {XW'(cell_x_i), YW'(cell_y_i), KW'(class_label_i[4:0])};

  // histogram memory
  logic [COUNT_WIDTH-1:0] mem_q [DEPTH];
  logic [COUNT_WIDTH-1:0] rdata_q, wdata, inc_val;
  logic [AW-1:0]          raddr, waddr, sample_addr_q;
  logic                   rd_en, we;

  logic [AW-1:0] sweep_cnt_q;
  logic          rd_v_q, rd_acc_q, rd_last_q;
  logic [AW-1:0] rd_addr_q;

  assign inc_val = (&rdata_q) ? rdata_q : rdata_q + 1'b1;
  assign rd_en   = cmd_i.rd_sample || cmd_i.sweep_rd;
  assign raddr   = cmd_i.sweep_rd ? sweep_cnt_q : sample_addr;
  assign we      = cmd_i.wr_sample || rd_v_q;
  assign waddr   = rd_v_q ? rd_addr_q : sample_addr_q;
  assign wdata   = rd_v_q ? '0 : inc_val;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_sample) begin
      sample_addr_q <= sample_addr;
    end
  end

  // sweep address and region decode
  logic [XW-1:0] sw_x;
  logic [YW-1:0] sw_y;
  logic [KW-1:0] sw_k;
  logic          sw_in, sw_last_k;

  assign sw_x      = sweep_cnt_q[AW-1 -: XW];
  assign sw_y      = sweep_cnt_q[KW+YW-1 -: YW];
  assign sw_k      = sweep_cnt_q[KW-1:0];
  assign sw_in     = (32'(sw_x) < 32'(map_w_q)) && (32'(sw_x) < MAX_X) &&
                     (32'(sw_y) < 32'(map_h_q)) && (32'(sw_y) < MAX_Y) &&
                     (32'(sw_k) < NUM_CLASSES);
  assign sw_last_k = (32'(sw_k) == NUM_CLASSES - 1);

  logic cell_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_cnt_q <= '0;
      rd_v_q      <= 1'b0;
      cell_v_q    <= 1'b0;
    end else begin
      if (cmd_i.sweep_rd) begin
        sweep_cnt_q <= sweep_cnt_q + 1'b1;
      end
      rd_v_q   <= cmd_i.sweep_rd;
      cell_v_q <= rd_v_q && rd_acc_q && rd_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= sweep_cnt_q;
    rd_acc_q  <= cmd_i.sweep_acc && en_q && sw_in;
    rd_last_q <= sw_last_k;
  end

  // per-cell total and majority, then report totals
  logic [PART_W-1:0]      part_q, cell_part_q, part_sum;
  logic [COUNT_WIDTH-1:0] top_q, cell_top_q, top_max;
  logic [TotW-1:0]        total_q, wrong_q;
  logic [SUM_W-1:0]       total_sum, wrong_sum;

  assign part_sum  = part_q + PART_W'(rdata_q);
  assign top_max   = (rdata_q > top_q) ? rdata_q : top_q;
  assign total_sum = SUM_W'(total_q) + SUM_W'(cell_part_q);
  assign wrong_sum = SUM_W'(wrong_q) + SUM_W'(cell_part_q - PART_W'(cell_top_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clear) begin
      part_q  <= '0;
      top_q   <= '0;
      total_q <= '0;
      wrong_q <= '0;
    end else begin
      if (rd_v_q && rd_acc_q) begin
        if (rd_last_q) begin
          cell_part_q <= part_sum;
          cell_top_q  <= top_max;
          part_q      <= '0;
          top_q       <= '0;
        end else begin
          part_q <= part_sum;
          top_q  <= top_max;
        end
      end
      if (cell_v_q) begin
        total_q <= (total_sum > SUM_W'({TotW{1'b1}})) ? '1 : TotW'(total_sum);
        wrong_q <= (wrong_sum > SUM_W'({TotW{1'b1}})) ? '1 : TotW'(wrong_sum);
      end
    end
  end

  // result register
  logic            out_v_q;
  logic [1:0]      status_q;
  logic [TotW-1:0] tot_out_q, wrong_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cmd_i.load_err || cmd_i.load_report) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_err) begin
      status_q    <= class_big ? ST_CLASS_RANGE : ST_CELL_RANGE;
      tot_out_q   <= '0;
      wrong_out_q <= '0;
    end else if (cmd_i.load_report) begin
      status_q    <= ST_REPORT;
      tot_out_q   <= total_q;
      wrong_out_q <= wrong_q;
    end
  end

  assign out_valid_o   = out_v_q;
  assign status_o      = status_q;
  assign total_items_o = tot_out_q;
  assign wrong_items_o = wrong_out_q;

  assign sts_o.item_finish = kind_i;
  assign sts_o.item_count  = !kind_i && en_q && !neg && !class_big && !cell_bad;
  assign sts_o.item_error  = !kind_i && en_q && !neg && (class_big || cell_bad);
  assign sts_o.sweep_last  = &sweep_cnt_q;
  assign sts_o.pipe_empty  = !rd_v_q && !cell_v_q;
  assign sts_o.out_free    = !out_v_q || out_ready_i;

endmodule
`default_nettype wire

>>> rtl/cluster_purity_error_counter.sv
// Cluster purity error counter: per-cell class histogram with majority-vote error report.
//
// Input stream: tuser is the item kind (0 labelled sample, 1 finish and report);
// tdata carries class_label, cell_x and cell_y. Output stream: tuser is the status
// (report, class out of range, cell out of range); tdata carries total_items and
// wrong_items. Configuration is a write-only port (map width, height, enable).
// A sample that counts is a read and then a saturating write-back on the
// single-port-per-direction histogram memory; a range error loads a result. A
// finish transaction starts a sweep over the whole store, one entry per cycle
// (2^(XW+YW+KW) entries, 8192 at the default sizes), reading and zeroing each
// entry, followed by a drain until the sweep pipeline is empty; then the report
// is loaded. Input is not taken meanwhile. After reset the same sweep runs once
// to clear the store; configuration writes are taken during it.
// Results sit in an output register; while a result is stalled, input is taken
// only when the register frees in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "cluster_purity_error_counter_defines.svh"
module cluster_purity_error_counter
  import cpec_pkg::*;
#(
  parameter int MAX_X       = MaxXDef,
  parameter int MAX_Y       = MaxYDef,
  parameter int NUM_CLASSES = NumClassesDef,
  parameter int COUNT_WIDTH = CountWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,   // class_label[5:0], cell_x[9:6], cell_y[13:10]
  input  logic                s_axis_tuser,   // kind
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [63:0]         m_axis_tdata,   // total_items[31:0], wrong_items[63:32]
  output logic [1:0]          m_axis_tuser    // status
);

  cmd_t            cmd;
  sts_t            sts;
  logic [TotW-1:0] total_items, wrong_items;
  logic            in_fire, out_stall, out_err;

  cpec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cpec_datapath #(
    .MAX_X       (MAX_X),
    .MAX_Y       (MAX_Y),
    .NUM_CLASSES (NUM_CLASSES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .kind_i        (s_axis_tuser),
    .class_label_i (s_axis_tdata[5:0]),
    .cell_x_i      (s_axis_tdata[9:6]),
    .cell_y_i      (s_axis_tdata[13:10]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .status_o      (m_axis_tuser),
    .total_items_o (total_items),
    .wrong_items_o (wrong_items)
  );

  assign s_axis_tready = cmd.in_ready;
  assign m_axis_tdata  = {wrong_items, total_items};

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_err   = m_axis_tvalid && (m_axis_tuser != ST_REPORT);

  // no input transaction while a stalled result is held
  `CPEC_ASSERT_IMP(a_no_accept_on_stall, clk_i, rst_ni, in_fire, !out_stall)
  // a finish transaction starts the sweep, which blocks input
  `CPEC_ASSERT_NXT(a_finish_blocks, clk_i, rst_ni, in_fire && s_axis_tuser, !s_axis_tready)
  // range errors carry zero counts
  `CPEC_ASSERT_IMP(a_err_zero, clk_i, rst_ni, out_err, m_axis_tdata == '0)
  // wrong count never exceeds the total
  `CPEC_ASSERT_IMP(a_wrong_le_total, clk_i, rst_ni, m_axis_tvalid, wrong_items <= total_items)

endmodule
`default_nettype wire

>>> test/tb_cluster_purity_error_counter.sv
// Self-checking testbench for the cluster purity error counter.
`timescale 1ns / 1ps
module tb_cluster_purity_error_counter;
  import cpec_pkg::*;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_FINISH = 1'b1;
  localparam int   SETTLE_CYC  = 8;

  typedef struct packed {
    logic       kind;
    logic [5:0] label;
    logic [3:0] cx;
    logic [3:0] cy;
  } lab_item_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] total;
    logic [31:0] wrong;
  } purity_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata = '0;   // class_label[5:0], cell_x[9:6], cell_y[13:10]
  logic                s_axis_tuser = 1'b0; // kind
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [63:0]         m_axis_tdata;        // total_items[31:0], wrong_items[63:32]
  logic [1:0]          m_axis_tuser;        // status

  cluster_purity_error_counter uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  lab_item_t sample_q[$];
  purity_t   purity_q[$];
  lab_item_t drv_item;
  logic      in_taken = 1'b0;
  int        send_gap_pct = 7;
  int        recv_stall_pct = 83;
  int        fail_cnt = 0;
  int        n_taken = 0;
  int        n_reports = 0;
  int        n_range_errs = 0;

  // map settings as the stimulus side knows them
  int cur_w = 16;
  int cur_h = 16;
  int cur_en = 1;

  // predictor state
  logic [CountWidthDef-1:0] cell_hist [MaxXDef][MaxYDef][NumClassesDef];
  logic [CfgDataW-1:0]      mdl_w;
  logic [CfgDataW-1:0]      mdl_h;
  logic                     mdl_en;

  task automatic clear_hist();
    for (int i = 0; i < MaxXDef; i++)
      for (int j = 0; j < MaxYDef; j++)
        for (int k = 0; k < NumClassesDef; k++)
          cell_hist[i][j][k] = '0;
  endtask

  task automatic score_item(input lab_item_t it);
    int      lbl;
    int      uw;
    int      uh;
    logic [63:0] part;
    logic [63:0] top;
    logic [63:0] total;
    logic [63:0] wrong;
    purity_t res;
    lbl = $signed(it.label);
    uw = (mdl_w > MaxXDef) ? MaxXDef : mdl_w;
    uh = (mdl_h > MaxYDef) ? MaxYDef : mdl_h;
    res = '{status: ST_REPORT, total: '0, wrong: '0};
    if (it.kind == KIND_SAMPLE) begin
      if (mdl_en && lbl >= 0) begin
        if (lbl >= NumClassesDef) begin
          res.status = ST_CLASS_RANGE;
          purity_q.insert(purity_q.size(), res);
        end else if (it.cx >= uw || it.cy >= uh) begin
          res.status = ST_CELL_RANGE;
          purity_q.insert(purity_q.size(), res);
        end else if (cell_hist[it.cx][it.cy][lbl] != '1) begin
          cell_hist[it.cx][it.cy][lbl] = cell_hist[it.cx][it.cy][lbl] + 1'b1;
        end
      end
    end else begin
      total = '0;
      wrong = '0;
      if (mdl_en) begin
        for (int i = 0; i < uw; i++)
          for (int j = 0; j < uh; j++) begin
            part = '0;
            top = '0;
            for (int k = 0; k < NumClassesDef; k++) begin
              part += cell_hist[i][j][k];
              if (cell_hist[i][j][k] > top) top = cell_hist[i][j][k];
            end
            total += part;
            wrong += part - top;
          end
      end
      res.total = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
      res.wrong = (wrong > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wrong[31:0];
      purity_q.insert(purity_q.size(), res);
      clear_hist();
    end
  endtask

  // result check first, then the input transaction of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_hist();
      mdl_w = MapWidthRst;
      mdl_h = MapHeightRst;
      mdl_en = 1'b1;
      in_taken <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (purity_q.size() == 0) begin
          $display("%0t: unexpected result status %0d total %0d wrong %0d", $realtime,
                   m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32]);
          fail_cnt++;
        end else begin
          purity_t exp_r;
          exp_r = purity_q.pop_front();
          if (exp_r.status == ST_REPORT) n_reports++;
          else n_range_errs++;
          if (m_axis_tuser !== exp_r.status) begin
            $display("%0t: status expected %0d got %0d", $realtime, exp_r.status,
                     m_axis_tuser);
            fail_cnt++;
          end
          if (m_axis_tdata[31:0] !== exp_r.total) begin
            $display("%0t: total_items expected %0d got %0d", $realtime, exp_r.total,
                     m_axis_tdata[31:0]);
            fail_cnt++;
          end
          if (m_axis_tdata[63:32] !== exp_r.wrong) begin
            $display("%0t: wrong_items expected %0d got %0d", $realtime, exp_r.wrong,
                     m_axis_tdata[63:32]);
            fail_cnt++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        lab_item_t it;
        it = '{kind: s_axis_tuser, label: s_axis_tdata[5:0], cx: s_axis_tdata[9:6],
               cy: s_axis_tdata[13:10]};
        score_item(it);
        n_taken++;
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CfgMapWidth:  mdl_w = cfg_data_i;
          CfgMapHeight: mdl_h = cfg_data_i;
          CfgEnable:    mdl_en = cfg_data_i[0];
          default: ;
        endcase
      end
      in_taken <= s_axis_tvalid && s_axis_tready;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        drv_item = sample_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= drv_item.kind;
        s_axis_tdata  <= {2'b00, drv_item.cy, drv_item.cx, drv_item.label};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic push(input logic kind, input int lbl, input int cx, input int cy);
    lab_item_t it;
    it = '{kind: kind, label: lbl[5:0], cx: cx[3:0], cy: cy[3:0]};
    sample_q.insert(sample_q.size(), it);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= CfgDataW'(val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic set_map(input int w, input int h, input int en);
    write_reg(CfgMapWidth, w);
    write_reg(CfgMapHeight, h);
    write_reg(CfgEnable, en);
    cur_w = w;
    cur_h = h;
    cur_en = en;
  endtask

  // sender has nothing left, no result outstanding, then a settle wait
  task automatic wait_drained();
    do begin
      @(posedge clk_i);
      #1;
    end while (sample_q.size() != 0 || s_axis_tvalid || purity_q.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic push_random(input int count);
    int uw;
    int uh;
    int pick;
    int lbl;
    int cx;
    int cy;
    for (int n = 0; n < count; n++) begin
      uw = (cur_w > MaxXDef) ? MaxXDef : cur_w;
      uh = (cur_h > MaxYDef) ? MaxYDef : cur_h;
      pick = $urandom_range(0, 99);
      lbl = int'($urandom_range(0, 63)) - 32;
      cx = $urandom_range(0, 15);
      cy = $urandom_range(0, 15);
      if (pick < 2) begin
        push(KIND_FINISH, lbl, cx, cy);
      end else begin
        if (pick < 80) begin
          lbl = $urandom_range(0, 1) ? $urandom_range(0, 3)
                                     : $urandom_range(0, NumClassesDef - 1);
          if (uw > 0) cx = $urandom_range(0, uw - 1);
          if (uh > 0) cy = $urandom_range(0, uh - 1);
          // crowd a few cells so majorities and ties form
          if (pick < 50) begin
            cx = cx % 3;
            cy = cy % 3;
          end
        end else if (pick < 88) begin
          lbl = 0 - int'($urandom_range(1, 32));
        end else if (pick < 94) begin
          lbl = $urandom_range(NumClassesDef, 31);
        end
        push(KIND_SAMPLE, lbl, cx, cy);
      end
    end
  endtask

  task automatic pick_map();
    int w;
    int h;
    case ($urandom_range(0, 9))
      0: begin w = 16; h = 16; end
      1: begin w = 1; h = 1; end
      2: begin w = $urandom_range(0, 1) ? 0 : 31; h = $urandom_range(0, 31); end
      3: begin w = $urandom_range(17, 31); h = $urandom_range(1, 16); end
      default: begin w = $urandom_range(1, 16); h = $urandom_range(1, 16); end
    endcase
    set_map(w, h, ($urandom_range(0, 5) != 0));
  endtask

  initial begin
    #32_000_000;
    $display("cluster_purity_error_counter verification failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: default 16x16 map, counting on
    push(KIND_SAMPLE, 0, 0, 0);
    push(KIND_SAMPLE, 19, 15, 15);
    push(KIND_SAMPLE, 19, 15, 15);
    push(KIND_SAMPLE, 5, 15, 15);
    push(KIND_SAMPLE, -1, 3, 3);
    push(KIND_SAMPLE, -32, 15, 0);
    push(KIND_SAMPLE, 20, 0, 15);
    push(KIND_SAMPLE, 31, 15, 15);
    push(KIND_FINISH, 0, 0, 0);
    wait_drained();
    // small map: cell bounds, class check ahead of cell check
    set_map(3, 2, 1);
    push(KIND_SAMPLE, 2, 3, 0);
    push(KIND_SAMPLE, 2, 0, 2);
    push(KIND_SAMPLE, 25, 9, 9);
    push(KIND_SAMPLE, 1, 2, 1);
    push(KIND_SAMPLE, 1, 2, 1);
    push(KIND_SAMPLE, 4, 2, 1);
    push(KIND_FINISH, 0, 0, 0);
    push(KIND_SAMPLE, 6, 1, 1);
    wait_drained();
    // zero-width map; leftover entry must be cleared without being counted
    set_map(0, 5, 1);
    push(KIND_SAMPLE, 0, 0, 0);
    push(KIND_FINISH, 0, 0, 0);
    wait_drained();
    set_map(31, 31, 1);
    push(KIND_SAMPLE, 3, 15, 15);
    push(KIND_FINISH, 0, 0, 0);
    push(KIND_SAMPLE, 3, 7, 7);
    wait_drained();
    // counting off: samples dropped, finish reports zero and clears
    set_map(16, 16, 0);
    push(KIND_SAMPLE, 3, 7, 7);
    push(KIND_SAMPLE, 25, 7, 7);
    push(KIND_FINISH, 0, 0, 0);
    wait_drained();
    set_map(16, 16, 1);
    push(KIND_FINISH, 0, 0, 0);
    wait_drained();

    for (int mode = 0; mode < 3; mode++) begin
      send_gap_pct   = (mode == 0) ? 7 : (mode == 1) ? 83 : 0;
      recv_stall_pct = (mode == 0) ? 83 : (mode == 1) ? 7 : 0;
      for (int seg = 0; seg < 6; seg++) begin
        pick_map();
        push_random(105);
        if ($urandom_range(0, 1)) push(KIND_FINISH, 0, 0, 0);
        wait_drained();
      end
    end
    repeat (16) @(posedge clk_i);

    $display("run: %0d input transactions, %0d reports, %0d range errors checked", n_taken,
             n_reports, n_range_errs);
    $display("maps from 0 to 31 cells per side, counting on and off, stalls on both sides");
    if (fail_cnt == 0) begin
      $display("cluster_purity_error_counter verification clean");
    end else begin
      $display("cluster_purity_error_counter verification failed");
    end
    $finish;
  end

endmodule
